// File: sv/frr_pkg.sv
// ----------------------------------------------------------------------------
// frr_pkg
// shared widths, sideband types and helpers of the fresnel reflect/refract unit
// ----------------------------------------------------------------------------
package frr_pkg;

   localparam int VEC_W      = 16;          // q2.14 direction component
   localparam int IOR_W      = 15;          // q2.13 refractive index
   localparam int ONE_Q13    = 8192;        // index 1.0
   localparam int CI_W       = 29;          // cosine magnitude, q.28, up to 1.0
   localparam int QNUM_W     = 61;          // etai^2 * sin^2 numerator
   localparam int QDEN_W     = 30;          // etat^2
   localparam int QDIV_Q_W   = 30;          // quotient bits of the snell divider
   localparam int RT_W       = 29;          // root bits of cos(theta_t)
   localparam int RNUM_W     = 61;          // fresnel ratio numerator
   localparam int RDEN_W     = 46;          // fresnel ratio denominator
   localparam int TNUM_W     = 34;          // transmitted component numerator
   localparam int ODIV_Q_W   = 17;          // quotient bits of the output dividers
   localparam int DATA_W     = 112;         // both tdata buses

   localparam logic [15:0] KR_FULL = 16'h8000;
   localparam logic [15:0] POS_MAX = 16'h7fff;
   localparam logic [15:0] NEG_MAX = 16'h8000;

   // per-ray values that ride alongside the snell divider and the square root
   typedef struct packed {
      logic [2:0][VEC_W-1:0] iv;
      logic [2:0][VEC_W-1:0] nv;
      logic [2:0][VEC_W-1:0] rv;
      logic                  leaving;
      logic                  tir;
      logic [IOR_W-1:0]      etai;
      logic [IOR_W-1:0]      etat;
      logic [CI_W-1:0]       ci;
   } side_type;

   // per-ray values that ride alongside the output dividers
   typedef struct packed {
      logic [2:0][VEC_W-1:0] rv;
      logic                  tir;
      logic [2:0]            neg;
      logic [2:0]            ovf;
   } tail_type;

   function automatic logic [15:0] sat16(input logic signed [35:0] v);
      logic [15:0] r;
      if (v > 36'sd32767) begin
         r = POS_MAX;
      end else if (v < -36'sd32768) begin
         r = NEG_MAX;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// File: sv/frr_delay.sv
// ----------------------------------------------------------------------------
// frr_delay
// sideband shift line with valid bits, stalls with the main pipeline
// ----------------------------------------------------------------------------
module frr_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_vld,
   input  logic [W-1:0] in_data,
   output logic         out_vld,
   output logic [W-1:0] out_data
);

   logic [DEPTH-1:0] vld_ff;
   logic [W-1:0]     dat_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dat_ff[0] <= in_data;
         for (int i = 1; i < DEPTH; i++) begin
            dat_ff[i] <= dat_ff[i-1];
         end
      end
   end

   assign out_vld  = vld_ff[DEPTH-1];
   assign out_data = dat_ff[DEPTH-1];

endmodule

// File: sv/frr_udiv.sv
// ----------------------------------------------------------------------------
// frr_udiv
// pipelined restoring divider, one quotient bit per stage, msb first
// expects num < den * 2^QUO_W
// ----------------------------------------------------------------------------
module frr_udiv #(
   parameter int NUM_W = 8,
   parameter int DEN_W = 4,
   parameter int QUO_W = 4
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [CW-1:0]    rem_ff [0:QUO_W-2];
   logic [DEN_W-1:0] den_ff [0:QUO_W-2];
   logic [QUO_W-1:0] quo_ff [0:QUO_W-1];

   for (genvar s = 0; s < QUO_W; s++) begin : g_step
      logic [CW-1:0]    rem_cur;
      logic [CW-1:0]    trial;
      logic [CW-1:0]    rem_in;
      logic [DEN_W-1:0] den_cur;
      logic [QUO_W-1:0] quo_cur;
      logic             ge;

      if (s == 0) begin : g_first
         assign rem_cur = CW'(num);
         assign den_cur = den;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[s-1];
         assign den_cur = den_ff[s-1];
         assign quo_cur = quo_ff[s-1];
      end

      assign trial  = CW'(den_cur) << (QUO_W - 1 - s);
      assign ge     = rem_cur >= trial;
      assign rem_in = ge ? rem_cur - trial : rem_cur;

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[s] <= {quo_cur[QUO_W-2:0], ge};
         end
      end

      if (s < QUO_W - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= rem_in;
               den_ff[s] <= den_cur;
            end
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

// File: sv/frr_isqrt.sv
// ----------------------------------------------------------------------------
// frr_isqrt
// pipelined floor square root, one root bit per stage
// ----------------------------------------------------------------------------
module frr_isqrt #(
   parameter int RT_W = 8
) (
   input  logic              clock,
   input  logic              en,
   input  logic [2*RT_W-1:0] rad,
   output logic [RT_W-1:0]   root
);

   localparam int RM_W = RT_W + 3;

   logic [RM_W-1:0]   rem_ff  [0:RT_W-2];
   logic [2*RT_W-1:0] rad_ff  [0:RT_W-2];
   logic [RT_W-1:0]   root_ff [0:RT_W-1];

   for (genvar s = 0; s < RT_W; s++) begin : g_step
      logic [RM_W-1:0]   rem_cur;
      logic [RM_W-1:0]   rem_sh;
      logic [RM_W-1:0]   trial;
      logic [RM_W-1:0]   rem_in;
      logic [2*RT_W-1:0] rad_cur;
      logic [RT_W-1:0]   root_cur;
      logic              ge;

      if (s == 0) begin : g_first
         assign rem_cur  = '0;
         assign rad_cur  = rad;
         assign root_cur = '0;
      end else begin : g_next
         assign rem_cur  = rem_ff[s-1];
         assign rad_cur  = rad_ff[s-1];
         assign root_cur = root_ff[s-1];
      end

      // bring down the next pair of radicand bits
      assign rem_sh = {rem_cur[RM_W-3:0], rad_cur[2*RT_W-1 -: 2]};
      assign trial  = RM_W'({root_cur, 2'b01});
      assign ge     = rem_sh >= trial;
      assign rem_in = ge ? rem_sh - trial : rem_sh;

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[s] <= {root_cur[RT_W-2:0], ge};
         end
      end

      if (s < RT_W - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= rem_in;
               rad_ff[s] <= rad_cur << 2;
            end
         end
      end
   end

   assign root = root_ff[RT_W-1];

endmodule

// File: sv/fresnel_reflect_refract_unit.sv
// ----------------------------------------------------------------------------
// fresnel_reflect_refract_unit
// fresnel reflection and snell refraction at a dielectric surface
// ----------------------------------------------------------------------------
// Takes one ray per clock (incident direction and normal in q2.14, material
// index in q2.13, outside medium fixed at 1.0) and returns the mirror
// direction, the refracted direction (the mirror direction under total
// internal reflection), the mean s/p fresnel reflectance in q1.15 and a
// total internal reflection flag. Throughput is one ray per cycle; the pipe
// holds the fully pipelined 30-step divider that forms the snell term, the
// 29-step square root for the transmitted cosine and the 17-step dividers for
// the fresnel ratios and the refracted components, plus twelve arithmetic
// stages. Results saturate to 16 bits. The whole pipe stalls as one while a
// finished result waits on rsp_tready; no beat is dropped or repeated.
// ----------------------------------------------------------------------------
module fresnel_reflect_refract_unit
   import frr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // dir_x, dir_y, dir_z, nrm_x, nrm_y, nrm_z, refr_index, one zero pad bit
   input  logic [DATA_W-1:0] req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // refl_x, refl_y, refl_z, trans_x, trans_y, trans_z, reflectance
   output logic [DATA_W-1:0] rsp_tdata,
   // total_internal
   output logic              rsp_tuser
);

   localparam int SIDE_DEPTH = QDIV_Q_W + RT_W;

   logic adv;

   // whole pipe moves unless the output beat is held
   assign adv        = ~rsp_tvalid | rsp_tready;
   assign req_tready = adv;

   // ---------------------------------------------------------------- stage 1
   // unpack, dot product terms, zero index taken as one lsb
   logic                    s1_vld_ff;
   logic [2:0][VEC_W-1:0]   s1_iv_ff;
   logic [2:0][VEC_W-1:0]   s1_nv_ff;
   logic [IOR_W-1:0]        s1_ior_ff;
   logic signed [31:0]      s1_p_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            s1_iv_ff[j] <= req_tdata[16*j +: 16];
            s1_nv_ff[j] <= req_tdata[48+16*j +: 16];
            s1_p_ff[j]  <= $signed(req_tdata[16*j +: 16]) * $signed(req_tdata[48+16*j +: 16]);
         end
         s1_ior_ff <= (req_tdata[110:96] == '0) ? IOR_W'(1) : req_tdata[110:96];
      end
   end

   // ---------------------------------------------------------------- stage 2
   // d = n.i, clamp cosine, pick the side the ray comes from
   logic signed [32:0] s2_d_in;
   logic [32:0]        s2_mag;
   logic               s2_leave;
   side_type           s2_sd_in;
   logic               s2_vld_ff;
   logic signed [32:0] s2_d_ff;
   side_type           s2_sd_ff;

   assign s2_d_in  = 33'(s1_p_ff[0]) + 33'(s1_p_ff[1]) + 33'(s1_p_ff[2]);
   assign s2_mag   = s2_d_in[32] ? 33'(-s2_d_in) : 33'(s2_d_in);
   assign s2_leave = s2_d_in > 33'sd0;   // grazing counts as entering

   always_comb begin
      s2_sd_in         = '0;
      s2_sd_in.iv      = s1_iv_ff;
      s2_sd_in.nv      = s1_nv_ff;
      s2_sd_in.leaving = s2_leave;
      s2_sd_in.ci      = (s2_mag > 33'h1000_0000) ? 29'h1000_0000 : s2_mag[CI_W-1:0];
      s2_sd_in.etai    = s2_leave ? s1_ior_ff : IOR_W'(ONE_Q13);
      s2_sd_in.etat    = s2_leave ? IOR_W'(ONE_Q13) : s1_ior_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_d_ff  <= s2_d_in;
         s2_sd_ff <= s2_sd_in;
      end
   end

   // ---------------------------------------------------------------- stage 3
   // n*d for the mirror, cos^2, squared indices
   logic                s3_vld_ff;
   logic signed [48:0]  s3_nd_ff [3];
   logic [56:0]         s3_cc_ff;
   logic [QDEN_W-1:0]   s3_ei2_ff;
   logic [QDEN_W-1:0]   s3_et2_ff;
   side_type            s3_sd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            s3_nd_ff[j] <= $signed(s2_sd_ff.nv[j]) * s2_d_ff;
         end
         s3_cc_ff  <= 57'(s2_sd_ff.ci) * 57'(s2_sd_ff.ci);
         s3_ei2_ff <= QDEN_W'(s2_sd_ff.etai) * QDEN_W'(s2_sd_ff.etai);
         s3_et2_ff <= QDEN_W'(s2_sd_ff.etat) * QDEN_W'(s2_sd_ff.etat);
         s3_sd_ff  <= s2_sd_ff;
      end
   end

   // ---------------------------------------------------------------- stage 4
   // mirror direction i - 2 n d, rounded half up; sin^2 in q.30
   logic [56:0]         s4_diff;
   logic [30:0]         s4_s2_in;
   side_type            s4_sd_in;
   logic                s4_vld_ff;
   logic [30:0]         s4_s2_ff;
   logic [QDEN_W-1:0]   s4_ei2_ff;
   logic [QDEN_W-1:0]   s4_et2_ff;
   side_type            s4_sd_ff;

   assign s4_diff  = 57'h100_0000_0000_0000 - s3_cc_ff;
   assign s4_s2_in = s4_diff[56:26];

   always_comb begin
      logic signed [51:0] rr;
      s4_sd_in = s3_sd_ff;
      for (int j = 0; j < 3; j++) begin
         rr = (52'($signed(s3_sd_ff.iv[j])) <<< 28) - (52'(s3_nd_ff[j]) <<< 1)
              + 52'sd134217728;
         s4_sd_in.rv[j] = sat16(36'(rr >>> 28));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_s2_ff  <= s4_s2_in;
         s4_ei2_ff <= s3_ei2_ff;
         s4_et2_ff <= s3_et2_ff;
         s4_sd_ff  <= s4_sd_in;
      end
   end

   // ---------------------------------------------------------------- stage 5
   // etai^2 * sin^2
   logic                s5_vld_ff;
   logic [QNUM_W-1:0]   s5_qnum_ff;
   logic [QDEN_W-1:0]   s5_et2_ff;
   side_type            s5_sd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (adv) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_qnum_ff <= QNUM_W'(s4_ei2_ff) * QNUM_W'(s4_s2_ff);
         s5_et2_ff  <= s4_et2_ff;
         s5_sd_ff   <= s4_sd_ff;
      end
   end

   // ---------------------------------------------------------------- stage 6
   // total internal reflection when the snell quotient reaches 1.0
   logic                s6_tir;
   side_type            s6_sd_in;
   logic                s6_vld_ff;
   logic [QNUM_W-1:0]   s6_qnum_ff;
   logic [QDEN_W-1:0]   s6_qden_ff;
   side_type            s6_sd_ff;

   assign s6_tir = s5_qnum_ff >= {1'b0, s5_et2_ff, 30'b0};

   always_comb begin
      s6_sd_in     = s5_sd_ff;
      s6_sd_in.tir = s6_tir;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (adv) begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_qnum_ff <= s6_tir ? '0 : s5_qnum_ff;   // keep the divider in range
         s6_qden_ff <= s5_et2_ff;
         s6_sd_ff   <= s6_sd_in;
      end
   end

   // ------------------------------------------------ snell divider and root
   logic [QDIV_Q_W-1:0] q_quo;
   logic [30:0]         k_val;
   logic [2*RT_W-1:0]   k_rad;
   logic [RT_W-1:0]     ct;
   logic                sd_vld;
   logic [$bits(side_type)-1:0] sd_bits;
   side_type            sd_q;

   frr_udiv #(
      .NUM_W (QNUM_W),
      .DEN_W (QDEN_W),
      .QUO_W (QDIV_Q_W)
   ) u_qdiv (
      .clock (clock),
      .en    (adv),
      .num   (s6_qnum_ff),
      .den   (s6_qden_ff),
      .quo   (q_quo)
   );

   // k = 1 - q in q.30, cos(theta_t) = sqrt(k) in q.28
   assign k_val = 31'h4000_0000 - {1'b0, q_quo};
   assign k_rad = {1'b0, k_val, 26'b0};

   frr_isqrt #(
      .RT_W (RT_W)
   ) u_sqrt (
      .clock (clock),
      .en    (adv),
      .rad   (k_rad),
      .root  (ct)
   );

   frr_delay #(
      .W     ($bits(side_type)),
      .DEPTH (SIDE_DEPTH)
   ) u_side (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (s6_vld_ff),
      .in_data  (s6_sd_ff),
      .out_vld  (sd_vld),
      .out_data (sd_bits)
   );

   assign sd_q = side_type'(sd_bits);

   // ---------------------------------------------------------------- stage 8
   // cross products of indices and cosines
   logic                s8_vld_ff;
   logic [43:0]         s8_tici_ff;
   logic [43:0]         s8_eict_ff;
   logic [43:0]         s8_eici_ff;
   logic [43:0]         s8_etct_ff;
   logic signed [31:0]  s8_eii_ff [3];
   side_type            s8_sd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else if (adv) begin
         s8_vld_ff <= sd_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_tici_ff <= 44'(sd_q.etat) * 44'(sd_q.ci);
         s8_eict_ff <= 44'(sd_q.etai) * 44'(ct);
         s8_eici_ff <= 44'(sd_q.etai) * 44'(sd_q.ci);
         s8_etct_ff <= 44'(sd_q.etat) * 44'(ct);
         for (int j = 0; j < 3; j++) begin
            s8_eii_ff[j] <= $signed({1'b0, sd_q.etai}) * $signed(sd_q.iv[j]);
         end
         s8_sd_ff <= sd_q;
      end
   end

   // ---------------------------------------------------------------- stage 9
   // s and p amplitude terms, refraction coefficient a
   logic signed [44:0]  s9_ns;
   logic signed [44:0]  s9_np;
   logic                s9_vld_ff;
   logic [44:0]         s9_ms_ff;
   logic [44:0]         s9_ds_ff;
   logic [44:0]         s9_mp_ff;
   logic [44:0]         s9_dp_ff;
   logic signed [44:0]  s9_a_ff;
   logic signed [31:0]  s9_eii_ff [3];
   side_type            s9_sd_ff;

   assign s9_ns = $signed({1'b0, s8_tici_ff}) - $signed({1'b0, s8_eict_ff});
   assign s9_np = $signed({1'b0, s8_eici_ff}) - $signed({1'b0, s8_etct_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_vld_ff <= 1'b0;
      end else if (adv) begin
         s9_vld_ff <= s8_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s9_ms_ff  <= s9_ns[44] ? 45'(-s9_ns) : 45'(s9_ns);
         s9_mp_ff  <= s9_np[44] ? 45'(-s9_np) : 45'(s9_np);
         s9_ds_ff  <= 45'(s8_tici_ff) + 45'(s8_eict_ff);
         s9_dp_ff  <= 45'(s8_eici_ff) + 45'(s8_etct_ff);
         s9_a_ff   <= s9_np;
         s9_eii_ff <= s8_eii_ff;
         s9_sd_ff  <= s8_sd_ff;
      end
   end

   // --------------------------------------------------------------- stage 10
   // ratio operands for rounding to q.15, n*a for the refracted ray
   logic                s10_vld_ff;
   logic [RNUM_W-1:0]   s10_rns_ff;
   logic [RNUM_W-1:0]   s10_rnp_ff;
   logic [RDEN_W-1:0]   s10_rds_ff;
   logic [RDEN_W-1:0]   s10_rdp_ff;
   logic signed [60:0]  s10_na_ff [3];
   logic signed [31:0]  s10_eii_ff [3];
   side_type            s10_sd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_vld_ff <= 1'b0;
      end else if (adv) begin
         s10_vld_ff <= s9_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s10_rns_ff <= RNUM_W'({s9_ms_ff, 16'b0}) + RNUM_W'(s9_ds_ff);
         s10_rnp_ff <= RNUM_W'({s9_mp_ff, 16'b0}) + RNUM_W'(s9_dp_ff);
         s10_rds_ff <= {s9_ds_ff, 1'b0};
         s10_rdp_ff <= {s9_dp_ff, 1'b0};
         for (int j = 0; j < 3; j++) begin
            s10_na_ff[j] <= $signed(s9_sd_ff.nv[j]) * s9_a_ff;
         end
         s10_eii_ff <= s9_eii_ff;
         s10_sd_ff  <= s9_sd_ff;
      end
   end

   // --------------------------------------------------------------- stage 11
   // refracted numerator pre-shifted by 2^28, sign folded out for the divider
   logic [TNUM_W-1:0]   s11_u   [3];
   tail_type            s11_tl_in;
   logic                s11_vld_ff;
   logic [TNUM_W-1:0]   s11_tn_ff [3];
   logic [IOR_W-1:0]    s11_etat_ff;
   logic [RNUM_W-1:0]   s11_rns_ff;
   logic [RNUM_W-1:0]   s11_rnp_ff;
   logic [RDEN_W-1:0]   s11_rds_ff;
   logic [RDEN_W-1:0]   s11_rdp_ff;
   tail_type            s11_tl_ff;

   always_comb begin
      logic signed [61:0] y;
      logic signed [61:0] ysum;
      logic signed [35:0] m;
      logic [35:0]        um;
      s11_tl_in     = '0;
      s11_tl_in.rv  = s10_sd_ff.rv;
      s11_tl_in.tir = s10_sd_ff.tir;
      for (int j = 0; j < 3; j++) begin
         // leaving the material flips the normal
         y    = s10_sd_ff.leaving ? -62'(s10_na_ff[j]) : 62'(s10_na_ff[j]);
         ysum = y + $signed(62'({s10_sd_ff.etat, 27'b0}));
         m    = 36'(s10_eii_ff[j]) + 36'(ysum >>> 28);
         um   = m[35] ? ~m : m;
         s11_u[j]         = um[TNUM_W-1:0];
         s11_tl_in.neg[j] = m[35];
         s11_tl_in.ovf[j] = s11_u[j] >= TNUM_W'({s10_sd_ff.etat, 17'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_vld_ff <= 1'b0;
      end else if (adv) begin
         s11_vld_ff <= s10_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            s11_tn_ff[j] <= s11_tl_in.ovf[j] ? '0 : s11_u[j];
         end
         s11_etat_ff <= s10_sd_ff.etat;
         s11_rns_ff  <= s10_rns_ff;
         s11_rnp_ff  <= s10_rnp_ff;
         s11_rds_ff  <= s10_rds_ff;
         s11_rdp_ff  <= s10_rdp_ff;
         s11_tl_ff   <= s11_tl_in;
      end
   end

   // ------------------------------------------------------- output dividers
   logic [ODIV_Q_W-1:0] rs_q;
   logic [ODIV_Q_W-1:0] rp_q;
   logic [ODIV_Q_W-1:0] tq [3];
   logic                tl_vld;
   logic [$bits(tail_type)-1:0] tl_bits;
   tail_type            tl_q;

   frr_udiv #(
      .NUM_W (RNUM_W),
      .DEN_W (RDEN_W),
      .QUO_W (ODIV_Q_W)
   ) u_rs_div (
      .clock (clock),
      .en    (adv),
      .num   (s11_rns_ff),
      .den   (s11_rds_ff),
      .quo   (rs_q)
   );

   frr_udiv #(
      .NUM_W (RNUM_W),
      .DEN_W (RDEN_W),
      .QUO_W (ODIV_Q_W)
   ) u_rp_div (
      .clock (clock),
      .en    (adv),
      .num   (s11_rnp_ff),
      .den   (s11_rdp_ff),
      .quo   (rp_q)
   );

   for (genvar g = 0; g < 3; g++) begin : g_tdiv
      frr_udiv #(
         .NUM_W (TNUM_W),
         .DEN_W (IOR_W),
         .QUO_W (ODIV_Q_W)
      ) u_tdiv (
         .clock (clock),
         .en    (adv),
         .num   (s11_tn_ff[g]),
         .den   (s11_etat_ff),
         .quo   (tq[g])
      );
   end

   frr_delay #(
      .W     ($bits(tail_type)),
      .DEPTH (ODIV_Q_W)
   ) u_tail (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (s11_vld_ff),
      .in_data  (s11_tl_ff),
      .out_vld  (tl_vld),
      .out_data (tl_bits)
   );

   assign tl_q = tail_type'(tl_bits);

   // --------------------------------------------------------------- stage 12
   // squared ratios, floor quotient restored to signed and saturated
   logic                  s12_vld_ff;
   logic [31:0]           s12_sqs_ff;
   logic [31:0]           s12_sqp_ff;
   logic [2:0][VEC_W-1:0] s12_tv_ff;
   logic [2:0][VEC_W-1:0] s12_rv_ff;
   logic                  s12_tir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s12_vld_ff <= 1'b0;
      end else if (adv) begin
         s12_vld_ff <= tl_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s12_sqs_ff <= 32'(rs_q[15:0]) * 32'(rs_q[15:0]);
         s12_sqp_ff <= 32'(rp_q[15:0]) * 32'(rp_q[15:0]);
         for (int j = 0; j < 3; j++) begin
            if (tl_q.ovf[j] | tq[j][16] | tq[j][15]) begin
               s12_tv_ff[j] <= tl_q.neg[j] ? NEG_MAX : POS_MAX;
            end else begin
               s12_tv_ff[j] <= tl_q.neg[j] ? ~tq[j][15:0] : tq[j][15:0];
            end
         end
         s12_rv_ff  <= tl_q.rv;
         s12_tir_ff <= tl_q.tir;
      end
   end

   // --------------------------------------------------------------- stage 13
   // mean reflectance rounded half up, output register
   logic [32:0]           kr_sum;
   logic [16:0]           kr_rnd;
   logic                  out_vld_ff;
   logic [DATA_W-1:0]     out_data_ff;
   logic                  out_tir_ff;

   assign kr_sum = 33'(s12_sqs_ff) + 33'(s12_sqp_ff) + 33'd32768;
   assign kr_rnd = kr_sum[32:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= s12_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff[47:0] <= s12_rv_ff;
         if (s12_tir_ff) begin
            out_data_ff[95:48]  <= s12_rv_ff;
            out_data_ff[111:96] <= KR_FULL;
         end else begin
            out_data_ff[95:48]  <= s12_tv_ff;
            out_data_ff[111:96] <= (kr_rnd > 17'd32768) ? KR_FULL : kr_rnd[15:0];
         end
         out_tir_ff <= s12_tir_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_tir_ff;

   // ------------------------------------------------------------- assertions
   // total internal reflection gives full reflectance and the mirror ray
   a_tir_result : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[111:96] == KR_FULL && rsp_tdata[95:48] == rsp_tdata[47:0])
      else $error("tir beat without full reflectance or mirror transmission");

   // reflectance never exceeds one
   a_kr_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[111:96] <= KR_FULL)
      else $error("reflectance above 1.0");

   // reset empties the pipe
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !s6_vld_ff && !sd_vld && !tl_vld)
      else $error("pipeline holds a beat after reset");

endmodule
